@@ design/rle_pkg.sv @@
// Shared types, constants and helper function of the election engine.
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

	localparam int unsigned ID_W    = 8;
	localparam int unsigned TERM_W  = 32;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned TMO_W   = 16;
	localparam int unsigned CNT_W   = 8;
	localparam int unsigned PEER_W  = 4;
	localparam int unsigned CFG_A_W = 3;
	localparam int unsigned CFG_D_W = 16;
	localparam int unsigned REQ_W   = 3;
	localparam int unsigned IN_D_W  = 72;
	localparam int unsigned OUT_D_W = 88;

	localparam logic [TMO_W-1:0] LFSR_TAPS      = 16'hB400;
	localparam logic [CNT_W-1:0] CNT_MAX        = 8'd255;
	localparam logic [TMO_W-1:0] RST_TMO_MIN    = 16'd1000;
	localparam logic [TMO_W-1:0] RST_TMO_MAX    = 16'd3000;
	localparam logic [TMO_W-1:0] RST_SPAN_MASK  = 16'd2047;
	localparam logic [TMO_W-1:0] RST_KA_PERIOD  = 16'd125;
	localparam logic [TMO_W-1:0] RST_LFSR_SEED  = 16'd44257;

	typedef enum logic [REQ_W-1:0] {
		REQ_START      = 3'd0,
		REQ_TICK       = 3'd1,
		REQ_VOTE_REQ   = 3'd2,
		REQ_VOTE_GRANT = 3'd3,
		REQ_KEEPALIVE  = 3'd4,
		REQ_RESET_TMO  = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_START,
		EV_TICK,
		EV_VOTE_REQ,
		EV_VOTE_GRANT,
		EV_REARM
	} ev_cls_t;

	typedef enum logic [1:0] {
		ROLE_UNAVAIL   = 2'd0,
		ROLE_FOLLOWER  = 2'd1,
		ROLE_CANDIDATE = 2'd2,
		ROLE_LEADER    = 2'd3
	} role_t;

	typedef enum logic [1:0] {
		KIND_REQ   = 2'd0,
		KIND_GRANT = 2'd1,
		KIND_KEEP  = 2'd2
	} kind_t;

	typedef enum logic [CFG_A_W-1:0] {
		CFG_SELF_ID   = 3'd0,
		CFG_PEER_CNT  = 3'd1,
		CFG_TMO_MIN   = 3'd2,
		CFG_TMO_MAX   = 3'd3,
		CFG_SPAN_MASK = 3'd4,
		CFG_KA_PERIOD = 3'd5,
		CFG_LFSR_SEED = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		ev_cls_t           cls;
		logic [TIME_W-1:0] now_ms;
		logic [ID_W-1:0]   remote_id;
		logic [TERM_W-1:0] msg_term_in;
	} event_t;

	function automatic logic [TMO_W-1:0] lfsr_step(input logic [TMO_W-1:0] cur);
		logic [TMO_W-1:0] v;
		v = (cur == '0) ? TMO_W'(1) : cur;
		if (v[0]) begin
			lfsr_step = (v >> 1) ^ LFSR_TAPS;
		end else begin
			lfsr_step = v >> 1;
		end
	endfunction

endpackage

`default_nettype wire

@@ design/rle_front.sv @@
// Front end: accepts input requests and classifies them into events.
`timescale 1ns / 1ps
`default_nettype none

module rle_front (
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [rle_pkg::IN_D_W-1:0]   s_axis_tdata,
	input  wire logic [rle_pkg::REQ_W-1:0]    s_axis_tuser,
	output logic                              push_valid,
	input  wire logic                         push_ready,
	output rle_pkg::event_t                   push_data
);

	rle_pkg::ev_cls_t cls;

	always_comb begin
		case (rle_pkg::req_t'(s_axis_tuser))
			rle_pkg::REQ_START:      cls = rle_pkg::EV_START;
			rle_pkg::REQ_TICK:       cls = rle_pkg::EV_TICK;
			rle_pkg::REQ_VOTE_REQ:   cls = rle_pkg::EV_VOTE_REQ;
			rle_pkg::REQ_VOTE_GRANT: cls = rle_pkg::EV_VOTE_GRANT;
			rle_pkg::REQ_KEEPALIVE,
			rle_pkg::REQ_RESET_TMO:  cls = rle_pkg::EV_REARM;
			default:                 cls = rle_pkg::EV_NONE;
		endcase
	end

	assign s_axis_tready         = push_ready;
	assign push_valid            = s_axis_tvalid;
	assign push_data.cls         = cls;
	assign push_data.now_ms      = s_axis_tdata[31:0];
	assign push_data.remote_id   = s_axis_tdata[39:32];
	assign push_data.msg_term_in = s_axis_tdata[71:40];

endmodule

`default_nettype wire

@@ design/rle_queue.sv @@
// Two-entry event queue between front end and execution back end.
`timescale 1ns / 1ps
`default_nettype none

module rle_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire rle_pkg::event_t  push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output rle_pkg::event_t       pop_data
);

	rle_pkg::event_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ design/rle_back.sv @@
// Back end: configuration, election state update and result register.
`timescale 1ns / 1ps
`default_nettype none

module rle_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rle_pkg::CFG_A_W-1:0]   cfg_addr,
	input  wire logic [rle_pkg::CFG_D_W-1:0]   cfg_wdata,
	input  wire logic                          ev_valid,
	output logic                               ev_ready,
	input  wire rle_pkg::event_t               ev_data,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [rle_pkg::OUT_D_W-1:0]        m_axis_tdata,
	output logic [1:0]                         m_axis_tuser
);

	logic [rle_pkg::ID_W-1:0]   self_id_q;
	logic [rle_pkg::PEER_W-1:0] peer_cnt_q;
	logic [rle_pkg::TMO_W-1:0]  tmo_min_q;
	logic [rle_pkg::TMO_W-1:0]  tmo_max_q;
	logic [rle_pkg::TMO_W-1:0]  span_mask_q;
	logic [rle_pkg::TMO_W-1:0]  ka_period_q;

	rle_pkg::role_t             role_q, role_d;
	logic [rle_pkg::TERM_W-1:0] term_q, term_d;
	logic                       voted_q, voted_d;
	logic [rle_pkg::ID_W-1:0]   voted_id_q, voted_id_d;
	logic                       ldr_known_q, ldr_known_d;
	logic [rle_pkg::ID_W-1:0]   ldr_id_q, ldr_id_d;
	logic [rle_pkg::CNT_W-1:0]  vote_cnt_q, vote_cnt_d;
	logic [rle_pkg::TMO_W-1:0]  cur_tmo_q, cur_tmo_d;
	logic [rle_pkg::TIME_W-1:0] vote_dl_q, vote_dl_d;
	logic [rle_pkg::TIME_W-1:0] ka_dl_q, ka_dl_d;
	logic [rle_pkg::TMO_W-1:0]  lfsr_q, lfsr_d;

	logic                       m_valid_q;
	logic [rle_pkg::OUT_D_W-1:0] m_data_q;
	logic [1:0]                 m_user_q;

	logic                       pop;
	logic [rle_pkg::TMO_W-1:0]  lfsr_nxt;
	logic [rle_pkg::TMO_W:0]    tmo_sum;
	logic [rle_pkg::TMO_W-1:0]  tmo_new;
	logic [rle_pkg::TIME_W-1:0] dl_new;
	logic [rle_pkg::TIME_W-1:0] dl_cur;
	logic [rle_pkg::TIME_W-1:0] ka_new;
	logic                       higher;
	logic                       vv_eff;
	logic [rle_pkg::ID_W-1:0]   vid_eff;
	logic [rle_pkg::CNT_W-1:0]  cnt_inc;
	logic                       seed_we;

	logic                       msg_valid;
	rle_pkg::kind_t             msg_kind;
	logic                       msg_bcast;
	logic [rle_pkg::ID_W-1:0]   msg_dest;
	logic [rle_pkg::TERM_W-1:0] msg_term;

	assign pop      = ev_valid & (~m_valid_q | m_axis_tready);
	assign ev_ready = pop;
	assign seed_we  = cfg_we & (rle_pkg::cfg_idx_t'(cfg_addr) == rle_pkg::CFG_LFSR_SEED);

	assign lfsr_nxt = rle_pkg::lfsr_step(lfsr_q);
	assign tmo_sum  = {1'b0, tmo_min_q} + {1'b0, lfsr_nxt & span_mask_q};
	assign tmo_new  = (tmo_sum > {1'b0, tmo_max_q}) ? tmo_max_q : tmo_sum[rle_pkg::TMO_W-1:0];
	assign dl_new   = ev_data.now_ms + rle_pkg::TIME_W'(tmo_new);
	assign dl_cur   = ev_data.now_ms + rle_pkg::TIME_W'(cur_tmo_q);
	assign ka_new   = ev_data.now_ms + rle_pkg::TIME_W'(ka_period_q);
	assign higher   = ev_data.msg_term_in > term_q;
	assign vv_eff   = higher ? 1'b0 : voted_q;
	assign vid_eff  = higher ? '0 : voted_id_q;
	assign cnt_inc  = (vote_cnt_q == rle_pkg::CNT_MAX) ? vote_cnt_q :
		vote_cnt_q + rle_pkg::CNT_W'(1);

	always_comb begin
		role_d      = role_q;
		term_d      = term_q;
		voted_d     = voted_q;
		voted_id_d  = voted_id_q;
		ldr_known_d = ldr_known_q;
		ldr_id_d    = ldr_id_q;
		vote_cnt_d  = vote_cnt_q;
		cur_tmo_d   = cur_tmo_q;
		vote_dl_d   = vote_dl_q;
		ka_dl_d     = ka_dl_q;
		lfsr_d      = lfsr_q;
		msg_valid   = 1'b0;
		msg_kind    = rle_pkg::KIND_REQ;
		msg_bcast   = 1'b0;
		msg_dest    = '0;
		msg_term    = '0;
		case (ev_data.cls)
			rle_pkg::EV_START: begin
				term_d      = term_q + rle_pkg::TERM_W'(1);
				voted_d     = 1'b0;
				voted_id_d  = '0;
				ldr_known_d = 1'b0;
				ldr_id_d    = '0;
				vote_cnt_d  = '0;
				lfsr_d      = lfsr_nxt;
				cur_tmo_d   = tmo_new;
				role_d      = rle_pkg::ROLE_FOLLOWER;
				vote_dl_d   = dl_new;
			end
			rle_pkg::EV_TICK: begin
				if (ev_data.now_ms > vote_dl_q && (role_q == rle_pkg::ROLE_FOLLOWER ||
						role_q == rle_pkg::ROLE_CANDIDATE)) begin
					role_d      = rle_pkg::ROLE_CANDIDATE;
					term_d      = term_q + rle_pkg::TERM_W'(1);
					voted_d     = 1'b1;
					voted_id_d  = self_id_q;
					ldr_known_d = 1'b0;
					ldr_id_d    = '0;
					vote_cnt_d  = rle_pkg::CNT_W'(1);
					lfsr_d      = lfsr_nxt;
					cur_tmo_d   = tmo_new;
					vote_dl_d   = dl_new;
					msg_valid   = 1'b1;
					msg_kind    = rle_pkg::KIND_REQ;
					msg_bcast   = 1'b1;
					msg_term    = term_q + rle_pkg::TERM_W'(1);
				end else if (role_q == rle_pkg::ROLE_LEADER && ev_data.now_ms > ka_dl_q) begin
					ka_dl_d   = ka_new;
					msg_valid = 1'b1;
					msg_kind  = rle_pkg::KIND_KEEP;
					msg_bcast = 1'b1;
					msg_term  = term_q;
				end
			end
			rle_pkg::EV_VOTE_REQ: begin
				if (ev_data.msg_term_in >= term_q) begin
					if (higher) begin
						voted_d     = 1'b0;
						voted_id_d  = '0;
						ldr_known_d = 1'b0;
						ldr_id_d    = '0;
						vote_cnt_d  = '0;
					end
					term_d = ev_data.msg_term_in;
					if (!vv_eff || vid_eff == ev_data.remote_id) begin
						role_d     = rle_pkg::ROLE_FOLLOWER;
						voted_d    = 1'b1;
						voted_id_d = ev_data.remote_id;
						msg_valid  = 1'b1;
						msg_kind   = rle_pkg::KIND_GRANT;
						msg_dest   = ev_data.remote_id;
						msg_term   = ev_data.msg_term_in;
					end
				end
			end
			rle_pkg::EV_VOTE_GRANT: begin
				if (ev_data.msg_term_in >= term_q) begin
					term_d     = ev_data.msg_term_in;
					vote_cnt_d = cnt_inc;
					if (cnt_inc > rle_pkg::CNT_W'(peer_cnt_q >> 1)) begin
						role_d      = rle_pkg::ROLE_LEADER;
						ldr_known_d = 1'b1;
						ldr_id_d    = self_id_q;
						msg_valid   = 1'b1;
						msg_kind    = rle_pkg::KIND_KEEP;
						msg_dest    = ev_data.remote_id;
						msg_term    = ev_data.msg_term_in;
					end
				end
			end
			rle_pkg::EV_REARM: begin
				vote_dl_d = dl_cur;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q   <= '0;
			peer_cnt_q  <= '0;
			tmo_min_q   <= rle_pkg::RST_TMO_MIN;
			tmo_max_q   <= rle_pkg::RST_TMO_MAX;
			span_mask_q <= rle_pkg::RST_SPAN_MASK;
			ka_period_q <= rle_pkg::RST_KA_PERIOD;
			lfsr_q      <= rle_pkg::RST_LFSR_SEED;
			role_q      <= rle_pkg::ROLE_UNAVAIL;
			term_q      <= '0;
			voted_q     <= 1'b0;
			voted_id_q  <= '0;
			ldr_known_q <= 1'b0;
			ldr_id_q    <= '0;
			vote_cnt_q  <= '0;
			cur_tmo_q   <= '0;
			vote_dl_q   <= '0;
			ka_dl_q     <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (rle_pkg::cfg_idx_t'(cfg_addr))
					rle_pkg::CFG_SELF_ID:   self_id_q   <= cfg_wdata[rle_pkg::ID_W-1:0];
					rle_pkg::CFG_PEER_CNT:  peer_cnt_q  <= cfg_wdata[rle_pkg::PEER_W-1:0];
					rle_pkg::CFG_TMO_MIN:   tmo_min_q   <= cfg_wdata;
					rle_pkg::CFG_TMO_MAX:   tmo_max_q   <= cfg_wdata;
					rle_pkg::CFG_SPAN_MASK: span_mask_q <= cfg_wdata;
					rle_pkg::CFG_KA_PERIOD: ka_period_q <= cfg_wdata;
					rle_pkg::CFG_LFSR_SEED: lfsr_q      <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (pop && !seed_we) begin
				lfsr_q <= lfsr_d;
			end
			if (pop) begin
				role_q      <= role_d;
				term_q      <= term_d;
				voted_q     <= voted_d;
				voted_id_q  <= voted_id_d;
				ldr_known_q <= ldr_known_d;
				ldr_id_q    <= ldr_id_d;
				vote_cnt_q  <= vote_cnt_d;
				cur_tmo_q   <= cur_tmo_d;
				vote_dl_q   <= vote_dl_d;
				ka_dl_q     <= ka_dl_d;
				m_valid_q   <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_user_q <= msg_kind;
			m_data_q <= {3'b000, ldr_id_d, ldr_known_d, term_d, role_d,
				msg_term, msg_dest, msg_bcast, msg_valid};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

@@ design/raft_leader_election_core.sv @@
// Top level of the single-node leader election engine.
`timescale 1ns / 1ps
`default_nettype none

// Each request (start, tick, vote request, vote granted, keep-alive, timeout
// reset) yields exactly one result carrying node status and at most one
// outgoing message. One request is taken per clock while the queue has room;
// a result is presented once the state update has popped its request from
// the queue and loaded the output register, which it does only while that
// register is empty or its result is leaving. A two-entry queue separates the
// request decoder from the state update, and the output register lets a new
// request enter while a result waits. Configuration writes take effect on
// the next edge; writing the seed also reloads the timeout generator.

module raft_leader_election_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [rle_pkg::CFG_A_W-1:0]   cfg_addr,
	input  wire logic [rle_pkg::CFG_D_W-1:0]   cfg_wdata,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// now_ms[31:0], remote_id[39:32], msg_term_in[71:40]
	input  wire logic [rle_pkg::IN_D_W-1:0]    s_axis_tdata,
	// req_type[2:0]
	input  wire logic [rle_pkg::REQ_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// msg_valid[0], msg_broadcast[1], msg_dest[9:2], msg_term_out[41:10],
	// node_role[43:42], node_term[75:44], leader_valid[76], leader_id[84:77]
	output logic [rle_pkg::OUT_D_W-1:0]        m_axis_tdata,
	// msg_kind[1:0]
	output logic [1:0]                         m_axis_tuser
);

	logic            push_valid;
	logic            push_ready;
	rle_pkg::event_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	rle_pkg::event_t pop_data;

	rle_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	rle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.ev_valid      (pop_valid),
		.ev_ready      (pop_ready),
		.ev_data       (pop_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

`default_nettype wire
